[rtl/timestamp_merge_watermark_unit_defines.svh]
// Assertion macros shared by the timestamp merge RTL.
// Both macros sample on clk and are disabled while rst_n is low.
`ifndef TIMESTAMP_MERGE_WATERMARK_UNIT_DEFINES_SVH
`define TIMESTAMP_MERGE_WATERMARK_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
// Property checked at every clock edge
`define TMW_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Consequent checked in the cycle after the antecedent
`define TMW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define TMW_ASSERT(label, prop, msg)
`define TMW_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

[rtl/tmw_pkg.sv]
package tmw_pkg;

    // Sizes
    localparam int STORE_DEPTH = 32;
    localparam int NUM_INPUTS  = 4;
    localparam int DATA_W      = 64;
    localparam int OPCODE_W    = 2;
    localparam int INDEX_W     = 2;
    localparam int KIND_W      = 2;

    localparam int IN_TDATA_W  = 4 * DATA_W;
    localparam int IN_TUSER_W  = OPCODE_W + INDEX_W;
    localparam int OUT_TDATA_W = 5 * DATA_W;
    localparam int OUT_TUSER_W = KIND_W;

    // End-time register select and scan counter widths
    localparam int INPUT_SEL_W = (NUM_INPUTS > 1) ? $clog2(NUM_INPUTS) : 1;
    localparam int INPUT_CNT_W = $clog2(NUM_INPUTS + 1);

    // Input opcodes
    localparam logic [OPCODE_W-1:0] OP_INSERT    = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_CHUNK_END = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_FLUSH     = 2'd2;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_HEADER = 2'd0;
    localparam logic [KIND_W-1:0] KIND_EVENT  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLOSE  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_DROP   = 2'd3;

    // Watermark seed when scanning end times
    localparam logic [DATA_W-1:0] NO_END_TIME = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic [DATA_W-1:0] id;
        logic [DATA_W-1:0] date;
        logic [DATA_W-1:0] dur;
    } event_t;

    // What one cell shows its neighbors
    typedef struct packed {
        logic   valid;
        logic   keep;
        event_t ev;
    } cell_link_t;

    // Broadcast command to every cell
    typedef struct packed {
        logic insert;
        logic shift;
    } cell_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
    } mark_status_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [DATA_W-1:0] id;
        logic [DATA_W-1:0] date;
        logic [DATA_W-1:0] dur;
        logic [DATA_W-1:0] span_start;
        logic [DATA_W-1:0] span_end;
        logic              last;
    } result_t;

endpackage

[rtl/tmw_cell.sv]
module tmw_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  tmw_pkg::cell_cmd_t  cmd,
    input  tmw_pkg::event_t     new_ev,
    input  tmw_pkg::cell_link_t left,
    input  tmw_pkg::cell_link_t right,
    output tmw_pkg::cell_link_t link
);
    import tmw_pkg::*;

    logic   valid_reg, valid_next;
    event_t ev_reg, ev_next;
    logic   keep;

    // Entry stays put on insert when it is not later than the new event
    assign keep = valid_reg && (ev_reg.date <= new_ev.date);

    // Insert: keep, take the new event, or take the left neighbor's entry.
    // Shift: take the right neighbor's entry.
    always_comb
    begin
        valid_next = valid_reg;
        ev_next    = ev_reg;
        if (cmd.shift)
        begin
            valid_next = right.valid;
            ev_next    = right.ev;
        end
        else if (cmd.insert && !keep)
        begin
            if (left.keep)
            begin
                valid_next = 1'b1;
                ev_next    = new_ev;
            end
            else
            begin
                valid_next = left.valid;
                ev_next    = left.ev;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        ev_reg <= ev_next;
    end

    assign link = '{valid: valid_reg, keep: keep, ev: ev_reg};

endmodule

[rtl/tmw_mark.sv]
module tmw_mark (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         wr_en,
    input  logic [tmw_pkg::INDEX_W-1:0]  wr_idx,
    input  logic [tmw_pkg::DATA_W-1:0]   wr_value,
    input  logic                         start,
    output tmw_pkg::mark_status_t        status,
    output logic [tmw_pkg::DATA_W-1:0]   mark
);
    import tmw_pkg::*;

    logic [DATA_W-1:0]      end_time_reg [NUM_INPUTS];
    logic [INPUT_CNT_W-1:0] cnt_reg, cnt_next;
    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [DATA_W-1:0]      mark_reg, mark_next;
    logic [DATA_W-1:0]      cur_time;

    // One end-time register per scan step
    assign cur_time = end_time_reg[cnt_reg[INPUT_SEL_W-1:0]];

    // Sequential minimum over the end-time registers
    always_comb
    begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        mark_next = mark_reg;
        if (start)
        begin
            cnt_next  = '0;
            busy_next = 1'b1;
            mark_next = NO_END_TIME;
        end
        else if (busy_reg)
        begin
            if (cur_time < mark_reg)
            begin
                mark_next = cur_time;
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == INPUT_CNT_W'(NUM_INPUTS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            for (int i = 0; i < NUM_INPUTS; i++)
            begin
                end_time_reg[i] <= '0;
            end
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
            // Out-of-range input indexes match no register
            for (int i = 0; i < NUM_INPUTS; i++)
            begin
                if (wr_en && (32'(wr_idx) == i))
                begin
                    end_time_reg[i] <= wr_value;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        mark_reg <= mark_next;
    end

    assign status = '{busy: busy_reg, done: done_reg};
    assign mark   = mark_reg;

endmodule

[rtl/timestamp_merge_watermark_unit.sv]
// Insert and chunk-end transactions: one can be accepted every cycle while idle with the output register free.
// Flush: scan end times for the watermark, send a header if none was sent yet, then, if the
// watermark reached the span end, release each stored event below it and send a span close.
// Results leave through a single output register, in the cycle after they are formed.
// rst_n (async, active low) clears store valid bits, end times, span end and header flag;
// stored event payloads are not cleared and there is no clearing pass.
`include "timestamp_merge_watermark_unit_defines.svh"

module timestamp_merge_watermark_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // event_id, event_date, event_duration, chunk_end_time
    input  logic [tmw_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // opcode, input_index
    input  logic [tmw_pkg::IN_TUSER_W-1:0]   s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // out_event_id, out_event_date, out_event_duration, span_start, span_end
    output logic [tmw_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    // kind
    output logic [tmw_pkg::OUT_TUSER_W-1:0]  m_axis_tuser,
    output logic                             m_axis_tlast
);
    import tmw_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MIN,
        ST_HEADER,
        ST_RELEASE,
        ST_CLOSE
    } state_t;

    state_t            state_reg, state_next;
    logic              header_sent_reg, header_sent_next;
    logic [DATA_W-1:0] span_end_reg, span_end_next;
    logic              out_valid_reg;
    result_t           out_reg;
    logic              out_load;
    result_t           out_next;

    logic              slot_free;
    logic              in_fire;
    logic [OPCODE_W-1:0] opcode;
    logic [INDEX_W-1:0]  input_index;
    event_t            in_ev;
    logic [DATA_W-1:0] chunk_end_time;

    cell_cmd_t         cell_cmd;
    cell_link_t        links [STORE_DEPTH];
    logic [STORE_DEPTH-1:0] valid_vec;
    logic [STORE_DEPTH:0]   fill_probe;
    logic              full;

    mark_status_t      mark_status;
    logic [DATA_W-1:0] mark;
    logic              mark_wr;
    logic              mark_start;
    logic              go;
    logic              head_release;

    // Input unpacking
    assign opcode         = s_axis_tuser[OPCODE_W-1:0];
    assign input_index    = s_axis_tuser[OPCODE_W +: INDEX_W];
    assign in_ev.id       = s_axis_tdata[0 +: DATA_W];
    assign in_ev.date     = s_axis_tdata[DATA_W +: DATA_W];
    assign in_ev.dur      = s_axis_tdata[2*DATA_W +: DATA_W];
    assign chunk_end_time = s_axis_tdata[3*DATA_W +: DATA_W];

    // Sorted store: a row of cells, head at index 0
    for (genvar i = 0; i < STORE_DEPTH; i++)
    begin : g_cell
        cell_link_t left_link;
        cell_link_t right_link;
        if (i == 0)
        begin : g_head
            assign left_link = '{valid: 1'b1, keep: 1'b1, ev: '0};
        end
        else
        begin : g_mid_l
            assign left_link = links[i-1];
        end
        if (i == STORE_DEPTH - 1)
        begin : g_tail
            assign right_link = '{valid: 1'b0, keep: 1'b0, ev: '0};
        end
        else
        begin : g_mid_r
            assign right_link = links[i+1];
        end
        tmw_cell u_cell (
            .clk    (clk),
            .rst_n  (rst_n),
            .cmd    (cell_cmd),
            .new_ev (in_ev),
            .left   (left_link),
            .right  (right_link),
            .link   (links[i])
        );
        assign valid_vec[i] = links[i].valid;
    end

    assign full = links[STORE_DEPTH-1].valid;

    // Watermark unit
    tmw_mark u_mark (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (mark_wr),
        .wr_idx   (input_index),
        .wr_value (chunk_end_time),
        .start    (mark_start),
        .status   (mark_status),
        .mark     (mark)
    );

    assign go           = (mark >= span_end_reg);
    assign head_release = links[0].valid && (links[0].ev.date < mark);

    // Handshake
    assign slot_free     = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE) && slot_free;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    // Control sequencer
    always_comb
    begin
        state_next       = state_reg;
        header_sent_next = header_sent_reg;
        span_end_next    = span_end_reg;
        cell_cmd         = '0;
        mark_wr          = 1'b0;
        mark_start       = 1'b0;
        out_load         = 1'b0;
        out_next         = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    unique case (opcode)
                        OP_INSERT:
                        begin
                            if (full)
                            begin
                                out_load      = 1'b1;
                                out_next.kind = KIND_DROP;
                                out_next.id   = in_ev.id;
                                out_next.date = in_ev.date;
                                out_next.dur  = in_ev.dur;
                                out_next.last = 1'b1;
                            end
                            else
                            begin
                                cell_cmd.insert = 1'b1;
                            end
                        end
                        OP_CHUNK_END:
                        begin
                            mark_wr = 1'b1;
                        end
                        OP_FLUSH:
                        begin
                            mark_start = 1'b1;
                            state_next = ST_MIN;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_MIN:
            begin
                if (mark_status.done)
                begin
                    state_next = ST_HEADER;
                end
            end
            ST_HEADER:
            begin
                if (!header_sent_reg)
                begin
                    if (slot_free)
                    begin
                        out_load            = 1'b1;
                        out_next.kind       = KIND_HEADER;
                        out_next.span_start = span_end_reg;
                        out_next.span_end   = span_end_reg;
                        out_next.last       = !go;
                        header_sent_next    = 1'b1;
                        state_next          = go ? ST_RELEASE : ST_IDLE;
                    end
                end
                else
                begin
                    state_next = go ? ST_RELEASE : ST_IDLE;
                end
            end
            ST_RELEASE:
            begin
                if (!head_release)
                begin
                    state_next = ST_CLOSE;
                end
                else if (slot_free)
                begin
                    out_load       = 1'b1;
                    out_next.kind  = KIND_EVENT;
                    out_next.id    = links[0].ev.id;
                    out_next.date  = links[0].ev.date;
                    out_next.dur   = links[0].ev.dur;
                    cell_cmd.shift = 1'b1;
                end
            end
            ST_CLOSE:
            begin
                if (slot_free)
                begin
                    out_load            = 1'b1;
                    out_next.kind       = KIND_CLOSE;
                    out_next.span_start = span_end_reg;
                    out_next.span_end   = mark;
                    out_next.last       = 1'b1;
                    span_end_next       = mark;
                    state_next          = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            header_sent_reg <= 1'b0;
            span_end_reg    <= '0;
            out_valid_reg   <= 1'b0;
            out_reg         <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            header_sent_reg <= header_sent_next;
            span_end_reg    <= span_end_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
                out_reg       <= out_next;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Output packing
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_reg.span_end, out_reg.span_start, out_reg.dur,
                            out_reg.date, out_reg.id};
    assign m_axis_tuser  = out_reg.kind;
    assign m_axis_tlast  = out_reg.last;

    // Valid cells must form a prefix: valid_vec + 1 is a power of two
    assign fill_probe = {1'b0, valid_vec} + (STORE_DEPTH + 1)'(1);

    `TMW_ASSERT(a_store_prefix, $onehot(fill_probe), "store valid bits are not a prefix")
    `TMW_ASSERT(a_drop_only_full, (out_load && (out_next.kind == KIND_DROP)) |-> full, "drop with room in store")
    `TMW_ASSERT(a_release_below_mark, (out_valid_reg && (out_reg.kind == KIND_EVENT)) |-> (out_reg.date < mark), "released event not below watermark")
    `TMW_ASSERT(a_min_running, (state_reg == ST_MIN) |-> (mark_status.busy || mark_status.done), "watermark scan not running")
    `TMW_ASSERT_NEXT(a_span_monotonic, 1'b1, span_end_reg >= $past(span_end_reg), "span end moved backward")

endmodule
